/* hdl/lcg_uniform_range_draw_macros.svh */
// Assertion macros for the uniform range draw block.
`ifndef LCG_UNIFORM_RANGE_DRAW_MACROS_SVH
`define LCG_UNIFORM_RANGE_DRAW_MACROS_SVH

`ifndef SYNTH
`define LURD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define LURD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LURD_ASSERT_ALWAYS(lbl, cond, msg)
`define LURD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/lurd_pkg.sv */
`default_nettype none
package lurd_pkg;

  localparam logic [31:0] LCG_MUL     = 32'd1103515245;
  localparam logic [30:0] LCG_ADD     = 31'd12345;
  localparam logic [31:0] ZERO_SUBST  = 32'd123459876;
  localparam logic [31:0] STATE_RESET = 32'd937186357;
  localparam logic [31:0] RANGE_SPAN  = 32'h8000_0000;

  localparam int RND_W = 8;
  localparam int DCNT_W = 5;
  localparam logic [DCNT_W-1:0] DCNT_LAST = '1;

  localparam logic KIND_SEED = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PDIV,
    S_BMUL,
    S_LMUL,
    S_LADD,
    S_CMP,
    S_QDIV,
    S_DONE
  } st_t;

endpackage
`default_nettype wire

/* hdl/lcg_uniform_range_draw.sv */
// Reseed request: loads the seed, then SHUFFLE_ROUNDS generator steps, no result.
// Draw request: a part size divide, a bound multiply, generator tries (multiply,
// add, compare) until one falls under the bound, a quotient divide, then the
// output register load, held while a pending result is stalled. A new request is
// taken only once the sequencer is back in idle. Shared multiplier and divider.
// Synchronous reset: generator state back to 937186357, sequencer idle, no result.
`default_nettype none
module lcg_uniform_range_draw #(
  parameter int SHUFFLE_ROUNDS = 50
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind,
  input  wire logic [31:0] seed_value,
  input  wire logic [30:0] upper_bound,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [30:0] value
);

`include "lcg_uniform_range_draw_macros.svh"

  lurd_pkg::st_t st, st_next;

  logic [31:0] gen;
  logic [31:0] prod;
  logic [31:0] bound;
  logic [31:0] dvs;
  logic [31:0] np1;
  logic [31:0] quo;
  logic [32:0] rem;
  logic [lurd_pkg::DCNT_W-1:0] dcnt;
  logic [lurd_pkg::RND_W-1:0]  rnd;
  logic        drawing;

  logic [31:0] mul_a, mul_b, mul_out;
  logic [32:0] rem_sh;
  logic [33:0] diff;
  logic        ge;
  logic [32:0] rem_step;
  logic [31:0] quo_step;
  logic        accept, raw_ok, out_free, div_last;

  assign accept   = in_valid && !in_stall;
  assign raw_ok   = {1'b0, gen[30:0]} < bound;
  assign out_free = !out_valid || !out_stall;
  assign div_last = dcnt == lurd_pkg::DCNT_LAST;
  assign mul_out  = mul_a * mul_b;

  always_comb begin
    in_stall = (st != lurd_pkg::S_IDLE);
    mul_a    = dvs;
    mul_b    = np1;
    if (st == lurd_pkg::S_LMUL) begin
      mul_a = (gen == 32'd0) ? lurd_pkg::ZERO_SUBST : gen;
      mul_b = lurd_pkg::LCG_MUL;
    end
    rem_sh   = {rem[31:0], quo[31]};
    diff     = {1'b0, rem_sh} - {2'b00, dvs};
    ge       = !diff[33];
    rem_step = ge ? diff[32:0] : rem_sh;
    quo_step = {quo[30:0], ge};
  end

  always_comb begin
    st_next = st;
    unique case (st)
      lurd_pkg::S_IDLE: begin
        if (accept) begin
          if (kind == lurd_pkg::KIND_DRAW) st_next = lurd_pkg::S_PDIV;
          else if (SHUFFLE_ROUNDS == 0)    st_next = lurd_pkg::S_IDLE;
          else                             st_next = lurd_pkg::S_LMUL;
        end
      end
      lurd_pkg::S_PDIV: if (div_last) st_next = lurd_pkg::S_BMUL;
      lurd_pkg::S_BMUL: st_next = lurd_pkg::S_LMUL;
      lurd_pkg::S_LMUL: st_next = lurd_pkg::S_LADD;
      lurd_pkg::S_LADD: begin
        if (drawing)                          st_next = lurd_pkg::S_CMP;
        else if (rnd == lurd_pkg::RND_W'(1))  st_next = lurd_pkg::S_IDLE;
        else                                  st_next = lurd_pkg::S_LMUL;
      end
      lurd_pkg::S_CMP:  st_next = raw_ok ? lurd_pkg::S_QDIV : lurd_pkg::S_LMUL;
      lurd_pkg::S_QDIV: if (div_last) st_next = lurd_pkg::S_DONE;
      lurd_pkg::S_DONE: if (out_free) st_next = lurd_pkg::S_IDLE;
      default:          st_next = lurd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= lurd_pkg::S_IDLE;
      gen       <= lurd_pkg::STATE_RESET;
      out_valid <= 1'b0;
      drawing   <= 1'b0;
      rnd       <= '0;
      dcnt      <= '0;
    end else begin
      st <= st_next;
      if (st == lurd_pkg::S_DONE && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall)       out_valid <= 1'b0;
      unique case (st)
        lurd_pkg::S_IDLE: begin
          if (accept) begin
            drawing <= (kind == lurd_pkg::KIND_DRAW);
            gen     <= (kind == lurd_pkg::KIND_DRAW) ? gen : seed_value;
            rnd     <= lurd_pkg::RND_W'(SHUFFLE_ROUNDS);
            dcnt    <= '0;
          end
        end
        lurd_pkg::S_PDIV, lurd_pkg::S_QDIV: dcnt <= dcnt + lurd_pkg::DCNT_W'(1);
        lurd_pkg::S_LADD: begin
          gen <= {1'b0, prod[30:0] + lurd_pkg::LCG_ADD};
          if (!drawing) rnd <= rnd - lurd_pkg::RND_W'(1);
        end
        lurd_pkg::S_CMP:  dcnt <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      lurd_pkg::S_IDLE: begin
        quo <= lurd_pkg::RANGE_SPAN;
        rem <= '0;
        dvs <= {1'b0, upper_bound} + 32'd1;
        np1 <= {1'b0, upper_bound} + 32'd1;
      end
      lurd_pkg::S_PDIV: begin
        quo <= quo_step;
        rem <= rem_step;
        if (div_last) dvs <= quo_step;
      end
      lurd_pkg::S_BMUL: bound <= mul_out;
      lurd_pkg::S_LMUL: prod <= mul_out;
      lurd_pkg::S_CMP: begin
        quo <= {1'b0, gen[30:0]};
        rem <= '0;
      end
      lurd_pkg::S_QDIV: begin
        quo <= quo_step;
        rem <= rem_step;
      end
      lurd_pkg::S_DONE: if (out_free) value <= quo[30:0];
      default: ;
    endcase
  end

  `LURD_ASSERT_NEXT(a_step_31bit, st == lurd_pkg::S_LADD, gen[31] == 1'b0, "state above 31 bits after step")
  `LURD_ASSERT_ALWAYS(a_part_nonzero, st != lurd_pkg::S_BMUL || dvs != 32'd0, "part size is zero")
  `LURD_ASSERT_ALWAYS(a_quo_in_range, st != lurd_pkg::S_DONE || quo < np1, "draw above upper bound")
  `LURD_ASSERT_NEXT(a_done_holds, st == lurd_pkg::S_DONE && out_valid && out_stall, st == lurd_pkg::S_DONE, "result overwrote pending output")

endmodule
`default_nettype wire

/* dv/lcg_uniform_range_draw_test.sv */
`default_nettype none
module lcg_uniform_range_draw_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SHUFFLE_ROUNDS = 50;
  localparam logic [31:0] LCG_MULT       = 32'd1103515245;
  localparam logic [31:0] LCG_INC        = 32'd12345;
  localparam logic [31:0] LCG_MASK       = 32'h7fff_ffff;
  localparam logic [31:0] ZERO_SEED      = 32'd123459876;
  localparam logic [31:0] POWER_ON_STATE = 32'd937186357;
  localparam logic [30:0] FULL_BOUND     = 31'h7fff_ffff;
  localparam int          RANDOM_REQUESTS = 1000;
  localparam int          QUIET_LIMIT     = 20000;
  localparam int          DRAIN_CYCLES    = 150;

  typedef struct {
    logic        kind;
    logic [31:0] seed;
    logic [30:0] bound;
    bit          fixed;
    logic [30:0] fixed_value;
  } request_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = 1'b0;
  logic [31:0] seed_value = '0;
  logic [30:0] upper_bound = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [30:0] value;

  logic [31:0] lcg_state;
  logic [30:0] expected_values[$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          error_count = 0;
  int          quiet_cycles = 0;

  request_row_t directed_rows[19] = '{
    '{lurd_pkg::KIND_DRAW, 32'h0000_0000, 31'd0,          1'b1, 31'd0},
    '{lurd_pkg::KIND_DRAW, 32'h0000_0000, FULL_BOUND,     1'b0, 31'd0},
    '{lurd_pkg::KIND_DRAW, 32'hffff_ffff, 31'd1,          1'b0, 31'd0},
    '{lurd_pkg::KIND_SEED, 32'h0000_0000, FULL_BOUND,     1'b0, 31'd0},
    '{lurd_pkg::KIND_DRAW, 32'h0000_0000, 31'h7fff_fffe,  1'b0, 31'd0},
    '{lurd_pkg::KIND_DRAW, 32'h0000_0000, 31'h4000_0000,  1'b0, 31'd0},
    '{lurd_pkg::KIND_DRAW, 32'h0000_0000, 31'h3fff_ffff,  1'b0, 31'd0},
    '{lurd_pkg::KIND_SEED, 32'hffff_ffff, FULL_BOUND,     1'b0, 31'd0},
    '{lurd_pkg::KIND_DRAW, 32'hffff_ffff, 31'd12345,      1'b0, 31'd0},
    '{lurd_pkg::KIND_SEED, 32'h8000_0000, 31'd0,          1'b0, 31'd0},
    '{lurd_pkg::KIND_DRAW, 32'h1234_5678, 31'd0,          1'b1, 31'd0},
    '{lurd_pkg::KIND_SEED, POWER_ON_STATE, 31'h2aaa_aaaa, 1'b0, 31'd0},
    '{lurd_pkg::KIND_DRAW, 32'h0000_0000, 31'd2,          1'b0, 31'd0},
    '{lurd_pkg::KIND_DRAW, 32'h5555_5555, 31'h5555_5555,  1'b0, 31'd0},
    '{lurd_pkg::KIND_SEED, 32'h2aaa_aaaa, 31'h5555_5555,  1'b0, 31'd0},
    '{lurd_pkg::KIND_DRAW, 32'haaaa_aaaa, 31'h2aaa_aaaa,  1'b0, 31'd0},
    '{lurd_pkg::KIND_DRAW, 32'h0000_0000, 31'd1000,       1'b0, 31'd0},
    '{lurd_pkg::KIND_SEED, 32'h0000_0001, 31'd0,          1'b0, 31'd0},
    '{lurd_pkg::KIND_DRAW, 32'h0000_0000, 31'd7,          1'b0, 31'd0}
  };

  lcg_uniform_range_draw #(
    .SHUFFLE_ROUNDS(SHUFFLE_ROUNDS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .seed_value (seed_value),
    .upper_bound(upper_bound),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] lcg_advance();
    logic [31:0] x;
    x = (lcg_state == 32'd0) ? ZERO_SEED : lcg_state;
    x = (x * LCG_MULT + LCG_INC) & LCG_MASK;
    lcg_state = x;
    return x;
  endfunction

  function automatic logic [30:0] draw_in_range(logic [30:0] n);
    logic [31:0] wide_n;
    logic [31:0] part;
    logic [31:0] limit;
    logic [31:0] raw;
    wide_n = {1'b0, n};
    if (n == FULL_BOUND) begin
      part = 32'd1;
    end else begin
      part = 32'd1 + (LCG_MASK - wide_n) / (wide_n + 32'd1);
    end
    limit = part * wide_n + (part - 32'd1);
    do begin
      raw = lcg_advance();
    end while (raw > limit);
    return 31'(raw / part);
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic issue_request(request_row_t row);
    logic [30:0] predicted;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= row.kind;
    seed_value  <= row.seed;
    upper_bound <= row.bound;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
      @(negedge clk);
    end
    if (row.kind == lurd_pkg::KIND_SEED) begin
      lcg_state = row.seed;
      repeat (SHUFFLE_ROUNDS) void'(lcg_advance());
    end else begin
      predicted = draw_in_range(row.bound);
      expected_values.push_back(row.fixed ? row.fixed_value : predicted);
    end
    @(negedge clk);
  endtask

  function automatic request_row_t random_request();
    request_row_t row;
    int pick;
    row.fixed       = 1'b0;
    row.fixed_value = '0;
    row.seed        = $urandom();
    row.bound       = 31'($urandom());
    row.kind        = ($urandom_range(99) < 15) ? lurd_pkg::KIND_SEED : lurd_pkg::KIND_DRAW;
    pick            = $urandom_range(99);
    if (row.kind == lurd_pkg::KIND_SEED) begin
      if (pick < 10) row.seed = 32'd0;
    end else if (pick < 20) begin
      row.bound = 31'($urandom_range(15));
    end else if (pick < 30) begin
      row.bound = FULL_BOUND - 31'($urandom_range(3));
    end else if (pick < 40) begin
      row.bound = 31'h4000_0000 - 31'd2 + 31'($urandom_range(4));
    end else if (pick < 55) begin
      row.bound = (31'd1 << $urandom_range(30)) - 31'($urandom_range(1));
    end
    return row;
  endfunction

  always @(negedge clk) begin
    out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin : result_check
    logic [30:0] want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_values.size() == 0) begin
          report_mismatch($sformatf("value %0d with no draw pending", value));
        end else begin
          want = expected_values.pop_front();
          if (value !== want)
            report_mismatch($sformatf("value %0d, expected %0d", value, want));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  initial begin
    lcg_state = POWER_ON_STATE;
    send_idle_pct = 29;
    recv_idle_pct = 72;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) issue_request(directed_rows[i]);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == RANDOM_REQUESTS / 3) begin
        send_idle_pct = 72;
        recv_idle_pct = 29;
      end else if (i == 2 * RANDOM_REQUESTS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      issue_request(random_request());
    end
    in_valid <= 1'b0;

    while (expected_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
